@@ hw/rtl/lsud_pkg.sv @@
package lsud_pkg;

  localparam int ELEM_W = 32;

  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/lsud_cell.sv @@
module lsud_cell (
  input  logic                              clk_i,
  input  lsud_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [lsud_pkg::ELEM_W-1:0] wr_data_i,
  input  logic signed [lsud_pkg::ELEM_W-1:0] nbr_data_i,
  output logic signed [lsud_pkg::ELEM_W-1:0] data_o
);
  import lsud_pkg::*;

  logic signed [ELEM_W-1:0] data_q;
  logic signed [ELEM_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.wr) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift) begin
      data_d = nbr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/list_set_union_intersect_diff.sv @@
// loads and clear: result in the cycle after the item, busy stays low; unused codes give none.
// union and difference: two passes, intersection one pass; each pass compares every
// outer ring entry with every inner ring entry. the rate is set by the ring walk, one
// compare of the two ring heads per cycle. results cannot be stalled.
// rst_ni is asynchronous, active low: both lists empty, block idle, no strobe.
module list_set_union_intersect_diff #(
  parameter int LIST_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic [2:0]                         operation_i,
  input  logic signed [lsud_pkg::ELEM_W-1:0] value_i,
  output logic                               busy,
  output logic                               strobe_o,
  output logic signed [lsud_pkg::ELEM_W-1:0] value_res_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);
  import lsud_pkg::*;

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(LIST_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(LIST_DEPTH);

  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_UNION  = 3'd3,
    OP_INTER  = 3'd4,
    OP_DIFF   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_ELEM  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    PH_COPY_A,
    PH_A_NOT_B,
    PH_B_NOT_A,
    PH_INTER
  } phase_e;

  state_e                state_q;
  phase_e                phase_q;
  logic [CW-1:0]         cnt_a_q, cnt_b_q;
  logic [IW-1:0]         inner_q, outer_q;
  logic                  found_q;
  logic                  pend_vld_q;
  logic signed [ELEM_W-1:0] pend_val_q;
  logic                  strobe_q;
  logic                  strobe_d;
  logic signed [ELEM_W-1:0] value_q;
  status_e               status_q;
  logic                  last_q;

  logic signed [ELEM_W-1:0] a_data [LIST_DEPTH];
  logic signed [ELEM_W-1:0] b_data [LIST_DEPTH];
  cell_ctrl_t               a_ctrl [LIST_DEPTH];
  cell_ctrl_t               b_ctrl [LIST_DEPTH];

  op_e                      op;
  logic                     accept;
  logic                     run;
  logic                     load_a, load_b;
  logic                     x_is_b;
  logic signed [ELEM_W-1:0] x_head, y_head;
  logic [CW-1:0]            cnt_x, cnt_y;
  logic                     x_valid, y_valid;
  logic                     match, hit;
  logic                     inner_end, phase_end;
  logic                     emit;
  logic                     shift_a, shift_b;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign op     = op_e'(operation_i);
  assign run    = (state_q == S_RUN);
  assign load_a = accept && (op == OP_LOAD_A) && (cnt_a_q != FullCnt);
  assign load_b = accept && (op == OP_LOAD_B) && (cnt_b_q != FullCnt);

  // outer list walks once per inner sweep, inner list steps every cycle while running
  assign x_is_b    = (phase_q == PH_B_NOT_A);
  assign x_head    = x_is_b ? b_data[0] : a_data[0];
  assign y_head    = x_is_b ? a_data[0] : b_data[0];
  assign cnt_x     = x_is_b ? cnt_b_q : cnt_a_q;
  assign cnt_y     = x_is_b ? cnt_a_q : cnt_b_q;
  assign x_valid   = CW'(outer_q) < cnt_x;
  assign y_valid   = CW'(inner_q) < cnt_y;
  assign match     = x_valid && y_valid && (x_head == y_head);
  assign hit       = found_q || match;
  assign inner_end = (inner_q == LastIdx);
  assign phase_end = inner_end && (outer_q == LastIdx);
  assign shift_a   = run && (x_is_b || inner_end);
  assign shift_b   = run && (!x_is_b || inner_end);

  assign strobe_d = (accept && (op == OP_LOAD_A || op == OP_LOAD_B || op == OP_CLEAR)) ||
                    (run && emit && pend_vld_q) || (state_q == S_FLUSH);

  always_comb begin
    emit = 1'b0;
    case (phase_q)
      PH_COPY_A:  emit = inner_end && x_valid;
      PH_INTER:   emit = match;
      default:    emit = inner_end && x_valid && !hit;
    endcase
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cells
    localparam int Nxt = (i + 1) % LIST_DEPTH;

    assign a_ctrl[i].wr    = load_a && (cnt_a_q == CW'(i));
    assign a_ctrl[i].shift = shift_a;
    assign b_ctrl[i].wr    = load_b && (cnt_b_q == CW'(i));
    assign b_ctrl[i].shift = shift_b;

    lsud_cell u_cell_a (
      .clk_i      (clk_i),
      .ctrl_i     (a_ctrl[i]),
      .wr_data_i  (value_i),
      .nbr_data_i (a_data[Nxt]),
      .data_o     (a_data[i])
    );

    lsud_cell u_cell_b (
      .clk_i      (clk_i),
      .ctrl_i     (b_ctrl[i]),
      .wr_data_i  (value_i),
      .nbr_data_i (b_data[Nxt]),
      .data_o     (b_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_COPY_A;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      inner_q    <= '0;
      outer_q    <= '0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_val_q <= '0;
      strobe_q   <= 1'b0;
      value_q    <= '0;
      status_q   <= ST_ELEM;
      last_q     <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            inner_q    <= '0;
            outer_q    <= '0;
            found_q    <= 1'b0;
            pend_vld_q <= 1'b0;
            unique case (op) inside
              OP_LOAD_A, OP_LOAD_B: begin
                value_q  <= '0;
                last_q   <= 1'b1;
                status_q <= (load_a || load_b) ? ST_DONE : ST_FULL;
                if (load_a) begin
                  cnt_a_q <= cnt_a_q + CW'(1);
                end
                if (load_b) begin
                  cnt_b_q <= cnt_b_q + CW'(1);
                end
              end
              OP_CLEAR: begin
                cnt_a_q  <= '0;
                cnt_b_q  <= '0;
                value_q  <= '0;
                last_q   <= 1'b1;
                status_q <= ST_DONE;
              end
              OP_UNION: begin
                phase_q <= PH_COPY_A;
                state_q <= S_RUN;
              end
              OP_INTER: begin
                phase_q <= PH_INTER;
                state_q <= S_RUN;
              end
              OP_DIFF: begin
                phase_q <= PH_A_NOT_B;
                state_q <= S_RUN;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          found_q <= inner_end ? 1'b0 : hit;
          inner_q <= inner_end ? '0 : inner_q + IW'(1);
          if (inner_end) begin
            outer_q <= (outer_q == LastIdx) ? '0 : outer_q + IW'(1);
          end
          // hold one element back so the final one can carry last
          if (emit) begin
            if (pend_vld_q) begin
              value_q  <= pend_val_q;
              status_q <= ST_ELEM;
              last_q   <= 1'b0;
            end
            pend_val_q <= x_head;
            pend_vld_q <= 1'b1;
          end
          if (phase_end) begin
            if (phase_q == PH_COPY_A || phase_q == PH_A_NOT_B) begin
              phase_q <= PH_B_NOT_A;
            end else begin
              state_q <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          last_q     <= 1'b1;
          value_q    <= pend_vld_q ? pend_val_q : '0;
          status_q   <= pend_vld_q ? ST_ELEM : ST_EMPTY;
          pend_vld_q <= 1'b0;
          state_q    <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign strobe_o    = strobe_q;
  assign value_res_o = value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_load_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_LOAD_A || op == OP_LOAD_B || op == OP_CLEAR)
    |=> strobe_o && last_o && (status_o == ST_DONE || status_o == ST_FULL))
    else $error("load or clear gave no single closing result");

  a_flush_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |=> strobe_o && last_o && !busy)
    else $error("set request did not close with a last result");

  a_open_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy && status_o == ST_ELEM)
    else $error("non-final result outside a set request");

  a_counts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cnt_a_q) == FullCnt && !$past(accept && op == OP_CLEAR) |-> cnt_a_q == FullCnt)
    else $error("full list A changed without clear");
`endif

endmodule
